>>> hdl/tmprof_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmprof_pkg
// Types, register indexes and helpers shared by the trapezoidal profile block.
// ----------------------------------------------------------------------------
package tmprof_pkg;

	// register indexes of the configuration port
	localparam logic [1:0] REG_TICK_PERIOD      = 2'd0;
	localparam logic [1:0] REG_MAX_VELOCITY     = 2'd1;
	localparam logic [1:0] REG_MAX_ACCELERATION = 2'd2;

	// reset values of the registers
	localparam logic [23:0] TICK_PERIOD_RST      = 24'd16777;
	localparam logic [30:0] MAX_VELOCITY_RST     = 31'h7FFF_FFFF;
	localparam logic [30:0] MAX_ACCELERATION_RST = 31'h7FFF_FFFF;

	// input item
	typedef struct packed {
		logic               kind;
		logic signed [31:0] target_position;
		logic signed [31:0] preset_position;
		logic signed [31:0] preset_velocity;
	} in_t;

	// result item
	typedef struct packed {
		logic signed [31:0] position_setpoint;
		logic signed [31:0] velocity_setpoint;
		logic signed [31:0] acceleration;
	} out_t;

	// clamp to the signed 32 bit range
	function automatic logic signed [31:0] sat32(input logic signed [33:0] x);
		logic signed [33:0] hi;
		logic signed [33:0] lo;
		hi = 34'sh0_7FFF_FFFF;
		lo = -34'sh0_8000_0000;
		if (x > hi)
			return 32'sh7FFF_FFFF;
		else if (x < lo)
			return 32'sh8000_0000;
		else
			return x[31:0];
	endfunction

endpackage

>>> hdl/trapezoidal_motion_profile.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trapezoidal_motion_profile
// Moves position and velocity setpoints toward a target on a trapezoidal
// velocity profile, one control tick per item, or presets both setpoints.
// ----------------------------------------------------------------------------
//  channel   handshake                 payload
//  in        in_valid / in_ready       in_data   (in_t)
//  out       out_valid / out_ready     out_data  (out_t)
//  cfg       cfg_valid / cfg_ready     cfg_index, cfg_data
//
//  A tick item goes from acceptance to a loaded result by way of eight
//  passes through the one shared 34x34 multiplier, the bit-serial
//  divider for the braking acceleration, and one step each for divider
//  set-up, acceleration choice, setpoint update and result load.
//  A preset item goes straight to the result load.
//  in_ready is high only while the sequencer is idle; a result waiting on
//  out_ready does not block the next acceptance, but holds the following one.
//  arst_n clears the setpoints and loads the register reset values.
// ----------------------------------------------------------------------------
module trapezoidal_motion_profile
	import tmprof_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  in_t         in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output out_t        out_data,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	typedef enum logic [13:0] {
		S_IDLE = 14'b00_0000_0000_0001,
		S_VV   = 14'b00_0000_0000_0010,
		S_BD   = 14'b00_0000_0000_0100,
		S_SV   = 14'b00_0000_0000_1000,
		S_R    = 14'b00_0000_0001_0000,
		S_RCH  = 14'b00_0000_0010_0000,
		S_DIV  = 14'b00_0000_0100_0000,
		S_DEC  = 14'b00_0000_1000_0000,
		S_AD   = 14'b00_0001_0000_0000,
		S_HL   = 14'b00_0010_0000_0000,
		S_HH   = 14'b00_0100_0000_0000,
		S_T1   = 14'b00_1000_0000_0000,
		S_FIN  = 14'b01_0000_0000_0000,
		S_OUT  = 14'b10_0000_0000_0000
	} state_t;

	state_t state_q;

	// configuration registers
	logic [23:0] tick_period_q;
	logic [30:0] max_velocity_q;
	logic [30:0] max_acceleration_q;

	// setpoints
	logic signed [31:0] pos_q;
	logic signed [31:0] vel_q;
	logic signed [31:0] acc_q;

	// per item working values
	logic [23:0] dt_q;
	logic [30:0] am_q;
	logic [32:0] em_q;
	logic [31:0] vm_q;
	logic        e_neg_q;
	logic        v_neg_q;
	logic [62:0] vv_q;
	logic        near_bd_q;
	logic [29:0] reach_q;
	logic signed [55:0] ad_q;
	logic [43:0] lo_q;
	logic signed [56:0] t2_q;

	// divider
	logic [55:0] dvd_q;
	logic [55:0] quo_q;
	logic [23:0] rem_q;
	logic [5:0]  cnt_q;

	// shared multiplier
	logic signed [33:0] mul_a;
	logic signed [33:0] mul_b;
	logic signed [67:0] prod_q;

	logic               out_valid_q;
	out_t               out_q;

	logic signed [32:0] err;
	logic [24:0]        rem_sh;
	logic               rem_ge;
	logic [30:0]        bq;
	logic signed [31:0] brake;
	logic signed [31:0] full;
	logic signed [31:0] acc_sel;
	logic signed [65:0] hdt;
	logic signed [57:0] t_sum;
	logic signed [33:0] pos_new;
	logic signed [33:0] vel_new;
	logic               out_free;

	assign in_ready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign out_free  = !out_valid_q || out_ready;

	// error from target at acceptance
	assign err = 33'(pos_q) - 33'(in_data.target_position);

	// multiplier operand selection
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			S_VV: begin
				mul_a = {2'b0, vm_q};
				mul_b = {2'b0, vm_q};
			end
			S_BD: begin
				mul_a = {1'b0, em_q};
				mul_b = {2'b0, am_q, 1'b0};
			end
			S_SV: begin
				mul_a = {3'b0, am_q};
				mul_b = {10'b0, dt_q};
			end
			S_R: begin
				mul_a = {3'b0, prod_q[54:24]};
				mul_b = {10'b0, dt_q};
			end
			S_AD: begin
				mul_a = {{2{acc_q[31]}}, acc_q};
				mul_b = {10'b0, dt_q};
			end
			S_HL: begin
				mul_a = {14'b0, prod_q[35:16]};
				mul_b = {10'b0, dt_q};
			end
			S_HH: begin
				mul_a = {{14{ad_q[55]}}, ad_q[55:36]};
				mul_b = {10'b0, dt_q};
			end
			S_T1: begin
				mul_a = {{2{vel_q[31]}}, vel_q};
				mul_b = {10'b0, dt_q};
			end
			S_IDLE, S_RCH, S_DIV, S_DEC, S_FIN, S_OUT: begin
				mul_a = '0;
				mul_b = '0;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// divider step and acceleration choice
	always_comb begin
		rem_sh  = {rem_q, dvd_q[55]};
		rem_ge  = (rem_sh >= {1'b0, dt_q});
		bq      = (quo_q > {25'b0, am_q}) ? am_q : quo_q[30:0];
		brake   = v_neg_q ? $signed({1'b0, bq}) : -$signed({1'b0, bq});
		full    = e_neg_q ? $signed({1'b0, am_q}) : -$signed({1'b0, am_q});
		if (e_neg_q != v_neg_q) begin
			if (near_bd_q || (em_q <= {3'b0, reach_q}))
				acc_sel = brake;
			else if (vm_q >= {1'b0, max_velocity_q})
				acc_sel = '0;
			else
				acc_sel = full;
		end else begin
			if (em_q <= {3'b0, reach_q})
				acc_sel = brake;
			else
				acc_sel = full;
		end
	end

	// integration terms
	always_comb begin
		hdt     = ($signed({{21{prod_q[44]}}, prod_q[44:0]}) <<< 20)
		        + $signed({22'b0, lo_q});
		t_sum   = 58'($signed(prod_q[56:0])) + 58'(t2_q);
		pos_new = 34'(pos_q) + 34'(t_sum >>> 24);
		vel_new = 34'(vel_q) + 34'(ad_q >>> 24);
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_period_q      <= TICK_PERIOD_RST;
			max_velocity_q     <= MAX_VELOCITY_RST;
			max_acceleration_q <= MAX_ACCELERATION_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_TICK_PERIOD:      tick_period_q      <= cfg_data[23:0];
				REG_MAX_VELOCITY:     max_velocity_q     <= cfg_data[30:0];
				REG_MAX_ACCELERATION: max_acceleration_q <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	// sequencer and state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pos_q       <= '0;
			vel_q       <= '0;
			acc_q       <= '0;
			out_valid_q <= 1'b0;
			cnt_q       <= '0;
		end else begin
			if (out_valid_q && out_ready && state_q != S_OUT)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						if (in_data.kind) begin
							pos_q   <= in_data.preset_position;
							vel_q   <= in_data.preset_velocity;
							acc_q   <= '0;
							state_q <= S_OUT;
						end else begin
							state_q <= S_VV;
						end
					end
				end
				S_VV:  state_q <= S_BD;
				S_BD:  state_q <= S_SV;
				S_SV:  state_q <= S_R;
				S_R:   state_q <= S_RCH;
				S_RCH: begin
					cnt_q   <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd55)
						state_q <= S_DEC;
				end
				S_DEC: begin
					acc_q   <= acc_sel;
					state_q <= S_AD;
				end
				S_AD:  state_q <= S_HL;
				S_HL:  state_q <= S_HH;
				S_HH:  state_q <= S_T1;
				S_T1:  state_q <= S_FIN;
				S_FIN: begin
					pos_q   <= sat32(pos_new);
					vel_q   <= sat32(vel_new);
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		if (state_q == S_IDLE) begin
			dt_q    <= (tick_period_q == '0) ? 24'd1 : tick_period_q;
			am_q    <= (max_acceleration_q == '0) ? 31'd1 : max_acceleration_q;
			e_neg_q <= err[32];
			em_q    <= err[32] ? 33'(-err) : 33'(err);
			v_neg_q <= vel_q[31];
			vm_q    <= vel_q[31] ? 32'(-33'(vel_q)) : 32'(vel_q);
		end
		if (state_q == S_BD)
			vv_q <= prod_q[62:0];
		if (state_q == S_SV)
			near_bd_q <= (prod_q[64:0] <= {2'b0, vv_q});
		if (state_q == S_RCH) begin
			reach_q <= prod_q[54:25];
			dvd_q   <= {vm_q, 24'b0};
			rem_q   <= '0;
			quo_q   <= '0;
		end
		if (state_q == S_DIV) begin
			dvd_q <= {dvd_q[54:0], 1'b0};
			quo_q <= {quo_q[54:0], rem_ge};
			rem_q <= rem_ge ? 24'(rem_sh - {1'b0, dt_q}) : rem_sh[23:0];
		end
		if (state_q == S_HL)
			ad_q <= prod_q[55:0];
		if (state_q == S_HH)
			lo_q <= prod_q[43:0];
		if (state_q == S_T1)
			t2_q <= 57'(hdt >>> 9);
		if (state_q == S_OUT && out_free) begin
			out_q.position_setpoint <= pos_q;
			out_q.velocity_setpoint <= vel_q;
			out_q.acceleration      <= acc_q;
		end
	end

endmodule
